/* design/gas_sensor_ppm_converter_core_defines.svh */
// Assertion macros for the gas sensor ppm converter.
`ifndef GAS_SENSOR_PPM_CONVERTER_CORE_DEFINES_SVH
`define GAS_SENSOR_PPM_CONVERTER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define GSP_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GSP_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define GSP_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define GSP_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

/* design/gspc_pkg.sv */
// ----------------------------------------------------------------------------
// gspc_pkg
// Types, constants and calibration tables of the gas sensor ppm converter.
// ----------------------------------------------------------------------------
package gspc_pkg;

  localparam int TablePoints = 8;
  localparam int MaxWindow   = 64;
  localparam int AdcW        = 10;
  localparam int AccW        = 40;
  localparam int WinW        = 7;
  localparam logic [AdcW-1:0] AdcFull = 10'd1023;
  localparam logic [31:0] Sat32 = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    REG_LOAD     = 3'd0,
    REG_NUM      = 3'd1,
    REG_DEN      = 3'd2,
    REG_CAL_WIN  = 3'd3,
    REG_MEAS_WIN = 3'd4
  } reg_idx_e;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_RSMUL = 9'b000000010,
    ST_RSDIV = 9'b000000100,
    ST_AVG   = 9'b000001000,
    ST_MUL2  = 9'b000010000,
    ST_DIV2  = 9'b000100000,
    ST_INTM  = 9'b001000000,
    ST_INTD  = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_e;

  function automatic logic [31:0] ratio_pt(input logic [3:0] i);
    case (i)
      4'd0: ratio_pt = 32'd3519;
      4'd1: ratio_pt = 32'd2649;
      4'd2: ratio_pt = 32'd1993;
      4'd3: ratio_pt = 32'd1369;
      4'd4: ratio_pt = 32'd1030;
      4'd5: ratio_pt = 32'd775;
      4'd6: ratio_pt = 32'd533;
      4'd7: ratio_pt = 32'd401;
      default: ratio_pt = 32'd0;
    endcase
  endfunction

  function automatic logic [31:0] ppm_pt(input logic [3:0] i);
    case (i)
      4'd0: ppm_pt = 32'd50;
      4'd1: ppm_pt = 32'd100;
      4'd2: ppm_pt = 32'd200;
      4'd3: ppm_pt = 32'd500;
      4'd4: ppm_pt = 32'd1000;
      4'd5: ppm_pt = 32'd2000;
      4'd6: ppm_pt = 32'd5000;
      4'd7: ppm_pt = 32'd10000;
      default: ppm_pt = 32'd0;
    endcase
  endfunction

endpackage

/* design/gas_sensor_ppm_converter_core.sv */
// ----------------------------------------------------------------------------
// gas_sensor_ppm_converter_core
// Turns ADC samples into sensor resistance, averages windows, stores a
// reference on calibration and reports ppm on measurement windows.
// ----------------------------------------------------------------------------
// Channel | Dir | Signals                     | Content
// s_axis  | in  | tvalid tready tdata tuser   | adc_sample, kind
// m_axis  | out | tvalid tready tdata tuser   | value, {clamped, result_kind}
// apb     | in  | psel penable pwrite paddr   | five configuration registers
//
// Each item runs shift-and-add and restoring division bit by bit: first for the
// resistance, and at the end of a window for a calibration or a measurement
// (averaging, scaling, and for a measurement also interpolation). One item is
// in work at a time; the output register holds a finished result, so the next
// item is taken while it waits, and the core stalls before its output stage
// until the register is free. Reset is asynchronous and clears the FSM state,
// the window, the reference and the output valid; there is no clearing pass.
`include "gas_sensor_ppm_converter_core_defines.svh"
module gas_sensor_ppm_converter_core
  import gspc_pkg::*;
#(
  parameter int MAX_WINDOW = MaxWindow
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [9:0] adc_sample
  input  logic        s_axis_tuser_i,   // [0] kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] value
  output logic [1:0]  m_axis_tuser_o,   // [0] result_kind, [1] clamped
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int MulW = 72;

  logic [19:0] load_q;
  logic [15:0] num_q, den_q;
  logic [6:0]  calw_q, measw_q;
  logic [31:0] ref_q;
  logic [AccW-1:0] acc_q;
  logic [WinW-1:0] cnt_q;
  logic wkind_q;

  state_e st_q;
  logic [MulW-1:0] a_q;    // multiplicand / dividend shift register
  logic [MulW-1:0] p_q;    // product / quotient
  logic [MulW-1:0] r_q;    // partial remainder
  logic [MulW-1:0] d_q;    // divisor
  logic [31:0] b_q;        // multiplier shift register
  logic [6:0]  bit_q;
  logic        kind_q;
  logic [AdcW-1:0] adc_q;
  logic [3:0]  seg_q;
  logic        clamp_q;

  logic        ov_q;
  logic [31:0] ov_data_q;
  logic        ov_kind_q, ov_clamp_q;

  logic [2:0] ridx;
  assign ridx = paddr[4:2];
  assign pready = 1'b1;

  always_comb begin
    case (ridx)
      REG_LOAD:     prdata = {12'd0, load_q};
      REG_NUM:      prdata = {16'd0, num_q};
      REG_DEN:      prdata = {16'd0, den_q};
      REG_CAL_WIN:  prdata = {25'd0, calw_q};
      REG_MEAS_WIN: prdata = {25'd0, measw_q};
      default:      prdata = 32'd0;
    endcase
  end

  logic wr;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= 20'd10000; num_q <= 16'd983; den_q <= 16'd100;
      calw_q <= 7'd30; measw_q <= 7'd5;
    end else if (wr) begin
      case (ridx)
        REG_LOAD:     load_q <= pwdata[19:0];
        REG_NUM:      num_q <= pwdata[15:0];
        REG_DEN:      den_q <= pwdata[15:0];
        REG_CAL_WIN:  calw_q <= pwdata[6:0];
        REG_MEAS_WIN: measw_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // Window length with zero acting as one and clamping at the maximum.
  function automatic logic [6:0] win_len(input logic [6:0] w);
    if (w == 7'd0) win_len = 7'd1;
    else if ({25'd0, w} > 32'(MAX_WINDOW)) win_len = 7'(MAX_WINDOW);
    else win_len = w;
  endfunction

  logic in_acc;
  assign s_axis_tready_o = (st_q == ST_IDLE);
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // One restoring-division step on the shared remainder and quotient.
  logic [MulW-1:0] rsh, rsub;
  logic            rge;
  assign rsh  = {r_q[MulW-2:0], a_q[MulW-1]};
  assign rge  = rsh >= d_q;
  assign rsub = rge ? rsh - d_q : rsh;

  logic [31:0] r1, r2, ratio;
  assign r1 = ratio_pt(seg_q);
  assign r2 = ratio_pt(seg_q + 4'd1);
  assign ratio = p_q[31:0];

  logic [AccW-1:0] rs_ext;
  logic [AccW:0]   acc_sum;
  assign rs_ext  = (adc_q == '0) ? AccW'(Sat32) : AccW'({p_q[30:0], rge});
  assign acc_sum = {1'b0, acc_q} + {1'b0, rs_ext};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; ref_q <= '0; acc_q <= '0; cnt_q <= '0; wkind_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (ov_q && m_axis_tready_i) ov_q <= 1'b0;
      case (st_q)
        ST_IDLE: if (in_acc) begin
          kind_q <= s_axis_tuser_i;
          adc_q  <= s_axis_tdata_i[AdcW-1:0];
          if (cnt_q != '0 && s_axis_tuser_i != wkind_q) begin
            acc_q <= '0; cnt_q <= '0;
          end
          wkind_q <= s_axis_tuser_i;
          a_q <= MulW'(load_q);
          b_q <= 32'(AdcFull - s_axis_tdata_i[AdcW-1:0]);
          p_q <= '0;
          bit_q <= 7'd0;
          st_q <= ST_RSMUL;
        end
        ST_RSMUL: begin
          if (b_q[0]) p_q <= p_q + a_q;
          a_q <= a_q << 1; b_q <= b_q >> 1;
          bit_q <= bit_q + 7'd1;
          if (bit_q == 7'd9) begin
            st_q <= ST_RSDIV; bit_q <= 7'd0;
          end
        end
        ST_RSDIV: begin
          if (bit_q == 7'd0) begin
            // Load the product into the dividend, aligned at the top.
            a_q <= p_q << (MulW - 32); r_q <= '0; p_q <= '0;
            d_q <= MulW'(adc_q);
            bit_q <= 7'd1;
          end else begin
            r_q <= rsub; a_q <= a_q << 1; p_q <= {p_q[MulW-2:0], rge};
            bit_q <= bit_q + 7'd1;
            if (bit_q == 7'd32) begin
              if ({1'b0, cnt_q} + 8'd1 >= {1'b0, win_len(kind_q ? measw_q : calw_q)}) begin
                acc_q <= '0; cnt_q <= '0;
                a_q <= MulW'(acc_sum[AccW-1:0]) << (MulW - AccW);
                r_q <= '0; p_q <= '0;
                d_q <= MulW'(win_len(kind_q ? measw_q : calw_q));
                bit_q <= 7'd0;
                st_q <= ST_AVG;
              end else begin
                acc_q <= acc_sum[AccW-1:0]; cnt_q <= cnt_q + 7'd1;
                st_q <= ST_IDLE;
              end
            end
          end
        end
        ST_AVG: begin
          r_q <= rsub; a_q <= a_q << 1; p_q <= {p_q[MulW-2:0], rge};
          bit_q <= bit_q + 7'd1;
          if (bit_q == 7'(AccW - 1)) begin
            a_q <= {p_q[MulW-2:0], rge};
            b_q <= kind_q ? 32'd1000 : 32'(den_q);
            p_q <= '0; bit_q <= 7'd0;
            st_q <= ST_MUL2;
          end
        end
        ST_MUL2: begin
          if (b_q[0]) p_q <= p_q + a_q;
          a_q <= a_q << 1; b_q <= b_q >> 1;
          bit_q <= bit_q + 7'd1;
          if (bit_q == 7'd15) begin
            bit_q <= 7'd0; st_q <= ST_DIV2;
          end
        end
        ST_DIV2: begin
          if (bit_q == 7'd0) begin
            a_q <= p_q; r_q <= '0; p_q <= '0;
            d_q <= kind_q ? MulW'(ref_q) : MulW'(num_q);
            bit_q <= 7'd1;
            if ((kind_q && ref_q == '0) || (!kind_q && num_q == '0)) begin
              p_q <= MulW'(Sat32); bit_q <= 7'd0; seg_q <= 4'd0;
              if (!kind_q) begin
                ref_q <= Sat32; st_q <= ST_OUT; clamp_q <= 1'b0;
              end else st_q <= ST_INTM;
            end
          end else begin
            r_q <= rsub; a_q <= a_q << 1; p_q <= {p_q[MulW-2:0], rge};
            bit_q <= bit_q + 7'd1;
            if (bit_q == 7'(MulW)) begin
              if ({p_q[MulW-2:0], rge} > MulW'(Sat32)) p_q <= MulW'(Sat32);
              if (!kind_q) begin
                ref_q <= ({p_q[MulW-2:0], rge} > MulW'(Sat32)) ? Sat32
                         : {p_q[30:0], rge};
                clamp_q <= 1'b0; st_q <= ST_OUT;
              end else begin
                seg_q <= 4'd0; bit_q <= 7'd0; st_q <= ST_INTM;
              end
            end
          end
        end
        ST_INTM: begin
          // Clamp at the table ends, or walk the table one segment a cycle, then multiply bit-serially.
          if (bit_q == 7'd0) begin
            clamp_q <= 1'b0;
            if (ratio >= ratio_pt(4'd0)) begin
              clamp_q <= ratio > ratio_pt(4'd0);
              p_q <= MulW'(ppm_pt(4'd0)); st_q <= ST_OUT;
            end else if (ratio <= ratio_pt(4'(TablePoints - 1))) begin
              clamp_q <= ratio < ratio_pt(4'(TablePoints - 1));
              p_q <= MulW'(ppm_pt(4'(TablePoints - 1))); st_q <= ST_OUT;
            end else if (ratio <= r1 && ratio >= r2) begin
              a_q <= MulW'(ppm_pt(seg_q + 4'd1) - ppm_pt(seg_q));
              b_q <= r1 - ratio;
              d_q <= MulW'(r1 - r2);
              r_q <= '0;
              bit_q <= 7'd1;
            end else seg_q <= seg_q + 4'd1;
          end else begin
            if (b_q[0]) r_q <= r_q + a_q;
            a_q <= a_q << 1; b_q <= b_q >> 1;
            bit_q <= bit_q + 7'd1;
            if (bit_q == 7'd16) begin
              a_q <= (b_q[0] ? r_q + a_q : r_q) << (MulW - 32);
              r_q <= '0; p_q <= '0; bit_q <= 7'd0;
              st_q <= ST_INTD;
            end
          end
        end
        ST_INTD: begin
          r_q <= rsub; a_q <= a_q << 1; p_q <= {p_q[MulW-2:0], rge};
          bit_q <= bit_q + 7'd1;
          if (bit_q == 7'd31) begin
            p_q <= MulW'(ppm_pt(seg_q)) + {p_q[MulW-2:0], rge};
            st_q <= ST_OUT;
          end
        end
        ST_OUT: if (!ov_q) begin
          ov_q <= 1'b1;
          ov_data_q <= kind_q ? p_q[31:0] : ref_q;
          ov_kind_q <= kind_q;
          ov_clamp_q <= kind_q && clamp_q;
          st_q <= ST_IDLE;
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = ov_data_q;
  assign m_axis_tuser_o  = {ov_clamp_q, ov_kind_q};

  `GSP_ASSERT_IMPL(a_onehot, clk_i, rst_ni, $onehot(st_q), "state not one-hot")
  `GSP_ASSERT_NEXT(a_hold, clk_i, rst_ni, ov_q && !m_axis_tready_i, ov_q && $stable(ov_data_q),
                   "result lost while stalled")
  `GSP_ASSERT_IMPL(a_calclamp, clk_i, rst_ni, !(ov_q && !ov_kind_q && ov_clamp_q),
                   "calibration result flagged clamped")

endmodule

/* test/tb_gas_sensor_ppm_converter_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gas_sensor_ppm_converter_core
// Drives ADC sample items into the converter under several register settings
// and idle patterns, and checks every result against a behavioral predictor or a directed expected value.
// ----------------------------------------------------------------------------
module tb_gas_sensor_ppm_converter_core
  import gspc_pkg::*;
();

  typedef struct packed {
    logic        knd;
    logic [31:0] val;
    logic        clmp;
  } result_t;

  typedef struct {
    logic        knd;
    logic [9:0]  adc;
    logic        has_exp;
    logic [31:0] exp_val;
    logic        exp_clmp;
  } row_t;

  localparam int WatchdogLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  gas_sensor_ppm_converter_core dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state and register copies.
  logic [19:0] load_q = 20'd10000;
  logic [15:0] num_q = 16'd983, den_q = 16'd100;
  logic [6:0]  calw_q = 7'd30, measw_q = 7'd5;
  logic [31:0] ref_ohms;
  logic [39:0] acc;
  logic [6:0]  cnt;
  logic        win_kind;

  result_t pending_results[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_idle = 0, recv_stall = 0;
  bit timed_out = 1'b0;

  function automatic logic [31:0] sat(input logic [127:0] v);
    return (v > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [31:0] interp_ppm(input logic [31:0] ratio, output logic clmp);
    int unsigned rp[8] = '{3519, 2649, 1993, 1369, 1030, 775, 533, 401};
    int unsigned pp[8] = '{50, 100, 200, 500, 1000, 2000, 5000, 10000};
    logic [63:0] q;
    clmp = 1'b0;
    if (ratio >= rp[0]) begin
      clmp = ratio > rp[0];
      return pp[0];
    end
    if (ratio <= rp[7]) begin
      clmp = ratio < rp[7];
      return pp[7];
    end
    for (int i = 0; i < 7; i++) begin
      if (ratio <= rp[i] && ratio >= rp[i+1]) begin
        q = 64'(pp[i+1] - pp[i]) * 64'(rp[i] - ratio) / 64'(rp[i] - rp[i+1]);
        return sat(128'(pp[i]) + 128'(q));
      end
    end
    return 32'd0;
  endfunction

  // Returns 1 and fills res when the sample closes a window.
  function automatic bit convert_sample(input logic knd, input logic [9:0] adc,
                                        output result_t res);
    logic [31:0] rs;
    logic [6:0]  w;
    logic [39:0] avg;
    logic [31:0] ratio;
    logic        c;
    res = '0;
    if (cnt != 0 && knd != win_kind) begin
      acc = '0;
      cnt = '0;
    end
    win_kind = knd;
    rs = (adc == 0) ? 32'hFFFF_FFFF : 32'((64'(load_q) * 64'(10'd1023 - adc)) / 64'(adc));
    acc = acc + 40'(rs);
    cnt = cnt + 7'd1;
    w = knd ? measw_q : calw_q;
    if (w == 0) w = 7'd1;
    if (w > MaxWindow) w = 7'(MaxWindow);
    if (cnt < w) return 1'b0;
    avg = acc / 40'(w);
    acc = '0;
    cnt = '0;
    res.knd = knd;
    if (!knd) begin
      ref_ohms = (num_q == 0) ? 32'hFFFF_FFFF : sat(128'(avg) * 128'(den_q) / 128'(num_q));
      res.val = ref_ohms;
    end else begin
      ratio = (ref_ohms == 0) ? 32'hFFFF_FFFF : sat(128'(avg) * 128'd1000 / 128'(ref_ohms));
      res.val = interp_ppm(ratio, c);
      res.clmp = c;
    end
    return 1'b1;
  endfunction

  // The valid stays high after an accepted item until the next call or the
  // drain decides, so it never gets two updates in one time step.
  task automatic send_sample(input logic knd, input logic [9:0] adc);
    result_t r;
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {6'd0, adc};
    s_axis_tuser_i  <= knd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (convert_sample(knd, adc, r)) pending_results.push_back(r);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0 && !timed_out) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] data);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 5'(idx) << 2; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_LOAD:     load_q = data[19:0];
      REG_NUM:      num_q = data[15:0];
      REG_DEN:      den_q = data[15:0];
      REG_CAL_WIN:  calw_q = data[6:0];
      REG_MEAS_WIN: measw_q = data[6:0];
      default: ;
    endcase
  endtask

  // Result checker and receiver stall.
  always @(posedge clk_i) begin
    result_t got, want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got = '{m_axis_tuser_o[0], m_axis_tdata_o, m_axis_tuser_o[1]};
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result kind=%0d value=%0d", got.knd, got.val);
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          errors++;
          if (errors <= 10)
            $display("Mismatch: expected kind=%0d value=%0d clamped=%0d, got %0d %0d %0d",
                     want.knd, want.val, want.clmp, got.knd, got.val, got.clmp);
        end
      end
    end
    m_axis_tready_i <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else if (rst_ni)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("Verification failed");
      $finish;
    end
  end

  task automatic random_phase(input int items, input int sidle, input int rstall);
    logic knd;
    logic [9:0] adc;
    int run;
    send_idle = sidle;
    recv_stall = rstall;
    for (int i = 0; i < items;) begin
      // Mostly full windows of one kind with random content, sometimes a lone sample.
      knd = $urandom_range(3) != 0;
      run = ($urandom_range(9) == 0) ? 1 : (knd ? measw_q : calw_q);
      if (run == 0) run = 1;
      if (run > MaxWindow) run = MaxWindow;
      for (int j = 0; j < run; j++) begin
        case ($urandom_range(9))
          0: adc = 10'd0;
          1: adc = 10'd1023;
          default: adc = 10'($urandom_range(1023));
        endcase
        send_sample(knd, adc);
        i++;
      end
    end
  endtask

  row_t directed[] = '{
    '{1'b1, 10'd512, 1'b1, 32'd50, 1'b1},    // measure before calibration: zero reference
    '{1'b0, 10'd0,   1'b0, 32'd0, 1'b0},     // zero sample
    '{1'b0, 10'd1023,1'b1, 32'd0, 1'b0},     // lowest resistance
    '{1'b1, 10'd1,   1'b0, 32'd0, 1'b0},     // kind change from calibration to measurement
    '{1'b0, 10'd300, 1'b0, 32'd0, 1'b0},
    '{1'b0, 10'd700, 1'b0, 32'd0, 1'b0},
    '{1'b1, 10'd400, 1'b0, 32'd0, 1'b0},
    '{1'b1, 10'd1023,1'b1, 32'd10000, 1'b1}, // ratio zero clamps high
    '{1'b1, 10'd0,   1'b1, 32'd50, 1'b1}     // huge ratio clamps low
  };

  initial begin
    ref_ohms = '0; acc = '0; cnt = '0; win_kind = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // One-sample windows so every directed row yields a result.
    write_reg(REG_CAL_WIN, 32'd1);
    write_reg(REG_MEAS_WIN, 32'd1);
    foreach (directed[k]) begin
      send_sample(directed[k].knd, directed[k].adc);
      if (directed[k].has_exp && pending_results.size() != 0) begin
        pending_results[$].val = directed[k].exp_val;
        pending_results[$].clmp = directed[k].exp_clmp;
      end
    end
    wait_drained();
    // Zero numerator, zero windows and out-of-range windows.
    write_reg(REG_NUM, 32'd0);
    write_reg(REG_CAL_WIN, 32'd0);
    write_reg(REG_MEAS_WIN, 32'd127);
    send_sample(1'b0, 10'd512);
    send_sample(1'b1, 10'd0);
    wait_drained();
    write_reg(REG_LOAD, 32'd10000);
    write_reg(REG_NUM, 32'd983);
    write_reg(REG_DEN, 32'd100);
    write_reg(REG_CAL_WIN, 32'd3);
    write_reg(REG_MEAS_WIN, 32'd2);
    random_phase(250, 0, 0);
    wait_drained();
    write_reg(REG_LOAD, 32'd1000000);
    write_reg(REG_NUM, 32'd1);
    write_reg(REG_DEN, 32'd65535);
    write_reg(REG_CAL_WIN, 32'd1);
    write_reg(REG_MEAS_WIN, 32'd4);
    random_phase(250, 81, 0);
    wait_drained();
    write_reg(REG_LOAD, 32'd1);
    write_reg(REG_NUM, 32'd65535);
    write_reg(REG_DEN, 32'd1);
    write_reg(REG_CAL_WIN, 32'd2);
    write_reg(REG_MEAS_WIN, 32'd1);
    random_phase(250, 0, 81);
    wait_drained();
    write_reg(REG_LOAD, 32'($urandom_range(1000000, 1)));
    write_reg(REG_NUM, 32'($urandom_range(65535, 1)));
    write_reg(REG_DEN, 32'($urandom_range(65535, 1)));
    write_reg(REG_CAL_WIN, 32'd64);
    write_reg(REG_MEAS_WIN, 32'd3);
    random_phase(250, 16, 16);
    wait_drained();
    if (pending_results.size() != 0) errors++;
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

/* files.f */
+incdir+design
design/gspc_pkg.sv
design/gas_sensor_ppm_converter_core.sv
test/tb_gas_sensor_ppm_converter_core.sv
